@@ design/mttc_pkg.sv @@
// Shared types and constants of the MIDI tempo/time converter.
// No dependencies; every other design file imports this package.
`default_nettype none

package mttc_pkg;

  localparam int OP_W       = 3;
  localparam int DATE_W     = 32;
  localparam int TUS_W      = 24;
  localparam int TPQ_W      = 15;
  localparam int TEMPO_W    = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 2;

  // Shared divider: 48-bit dividend, 21-bit divisor, one quotient bit per cycle
  localparam int DIV_W = 48;
  localparam int DVS_W = 21;
  localparam int CNT_W = $clog2(DIV_W);

  // Shared multiplier: 32 x 21 bits
  localparam int PROD_W = DATE_W + TEMPO_W;

  localparam logic [CFG_IDX_W-1:0] REG_TPQ       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEF_TEMPO = CFG_IDX_W'(1);

  localparam logic [TPQ_W-1:0]   TPQ_RESET       = TPQ_W'(480);
  localparam logic [TEMPO_W-1:0] DEF_TEMPO_RESET = TEMPO_W'(50000);
  localparam logic [TEMPO_W-1:0] TPT_RESET       = TEMPO_W'(104);
  localparam logic [TPQ_W-1:0]   TREM_RESET      = TPQ_W'(80);

  localparam logic [DVS_W-1:0]  US_PER_UNIT = DVS_W'(10);
  localparam logic [DVS_W-1:0]  UNITS_PER_MS_DIV = DVS_W'(100);
  localparam logic [DATE_W-1:0] UNITS_PER_MS = DATE_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_RESTART   = 3'd0,
    OP_SET_TEMPO = 3'd1,
    OP_T2TIME    = 3'd2,
    OP_TIME2T    = 3'd3,
    OP_T2MS      = 3'd4,
    OP_MS2T      = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_TUS_DIV,
    S_TUS_WAIT,
    S_T2T_DELTA,
    S_T2T_MUL_Q,
    S_T2T_MUL_R,
    S_T2T_DIV,
    S_T2T_WAIT,
    S_T2T_FIN,
    S_MS_DIV,
    S_MS_WAIT,
    S_K_DELTA,
    S_K_MUL,
    S_K_DIV,
    S_K_WAIT,
    S_K_FIN,
    S_LOAD_DIV,
    S_LOAD_WAIT,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ design/mttc_in_if.sv @@
// Input channel of the converter: valid/ready plus op, date and tempo.
// Depends on mttc_pkg for the field widths.
`default_nettype none

interface mttc_in_if import mttc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DATE_W-1:0] date;
  logic [TUS_W-1:0]  tempo_us;

  modport source (output valid, output op, output date, output tempo_us, input ready);
  modport sink   (input valid, input op, input date, input tempo_us, output ready);
endinterface

`default_nettype wire

@@ design/mttc_out_if.sv @@
// Result channel of the converter: valid/ready plus the converted date.
// Depends on mttc_pkg for the field width.
`default_nettype none

interface mttc_out_if import mttc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATE_W-1:0] converted_date;

  modport source (output valid, output converted_date, input ready);
  modport sink   (input valid, input converted_date, output ready);
endinterface

`default_nettype wire

@@ design/midi_tempo_time_converter_unit.sv @@
// MIDI tempo converter top level: sequencer, shared multiplier, state registers.
// Depends on mttc_pkg, mttc_in_if, mttc_out_if and mttc_divider.
//
// Usage:
//   in_item carries one command: op, date and tempo_us. It is taken only while
//   the sequencer is idle; one command runs to completion before the next.
//   out_item carries converted_date for ticks/time/ms conversions; restart and
//   set tempo produce no result. cfg_we/cfg_index/cfg_data write the
//   resolution (index 0) and the restart tempo (index 1); write only while idle.
//   Divisions in the shared divider, run one at a time, dominate each command.
//   The result sits in an output register; a new command is accepted while it
//   waits, but the next result is held in the sequencer until the register is
//   taken, so a stalled receiver loses nothing.
//   Reset (rst, synchronous) restores resolution 480, restart tempo 50000,
//   anchor zero and the default tempo, and empties the output register.
`default_nettype none

module midi_tempo_time_converter_unit import mttc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mttc_in_if.sink               in_item,
  mttc_out_if.source            out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  // Configuration and tempo state
  logic [TPQ_W-1:0]   tpq;
  logic [TEMPO_W-1:0] default_tempo;
  logic [DATE_W-1:0]  anchor_ticks;
  logic [DATE_W-1:0]  anchor_time;
  logic [TEMPO_W-1:0] current_tempo;
  logic [TEMPO_W-1:0] tempo_per_tick;
  logic [TPQ_W-1:0]   tempo_remainder;

  // Working registers
  logic [OP_W-1:0]    op_r;
  logic [DATE_W-1:0]  date_r;
  logic [TUS_W-1:0]   tus_r;
  logic [TEMPO_W-1:0] new_tempo;
  logic [DATE_W-1:0]  delta;
  logic               neg;
  logic [PROD_W-1:0]  prod;
  logic [DATE_W-1:0]  acc;
  logic [DATE_W-1:0]  result_val;
  logic               out_valid;
  logic [DATE_W-1:0]  out_data;

  // Control and shared units
  logic               in_ready;
  logic               out_load;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [DVS_W-1:0]   div_rem;
  logic [TEMPO_W-1:0] mul_b;

  logic [TPQ_W-1:0]   eff_tpq;
  logic [TEMPO_W-1:0] tus_q;
  logic [DATE_W-1:0]  t2t_val;
  logic [DATE_W-1:0]  k_sat;
  op_t                op_e;

  assign op_e    = op_t'(op_r);
  assign eff_tpq = (tpq == '0) ? TPQ_W'(1) : tpq;
  assign tus_q   = div_quo[TEMPO_W-1:0];
  assign t2t_val = neg ? (anchor_time - acc) : (anchor_time + acc);
  assign k_sat   = (div_quo[DIV_W-1:DATE_W] != '0) ? '1 : div_quo[DATE_W-1:0];

  mttc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_item.valid) state_next = S_DECODE;
      S_DECODE: begin
        case (op_e)
          OP_RESTART:          state_next = S_LOAD_DIV;
          OP_SET_TEMPO:        state_next = S_TUS_DIV;
          OP_T2TIME, OP_T2MS:  state_next = S_T2T_DELTA;
          OP_TIME2T, OP_MS2T:  state_next = S_K_DELTA;
          default:             state_next = S_IDLE;
        endcase
      end
      S_TUS_DIV:   state_next = S_TUS_WAIT;
      S_TUS_WAIT: begin
        if (div_done) begin
          // drop a zero or unchanged tempo
          if (tus_q == '0 || tus_q == current_tempo) state_next = S_IDLE;
          else state_next = S_T2T_DELTA;
        end
      end
      S_T2T_DELTA: state_next = S_T2T_MUL_Q;
      S_T2T_MUL_Q: state_next = S_T2T_MUL_R;
      S_T2T_MUL_R: state_next = S_T2T_DIV;
      S_T2T_DIV:   state_next = S_T2T_WAIT;
      S_T2T_WAIT:  if (div_done) state_next = S_T2T_FIN;
      S_T2T_FIN: begin
        case (op_e)
          OP_T2MS:      state_next = S_MS_DIV;
          OP_SET_TEMPO: state_next = S_LOAD_DIV;
          default:      state_next = S_RESULT;
        endcase
      end
      S_MS_DIV:    state_next = S_MS_WAIT;
      S_MS_WAIT:   if (div_done) state_next = S_RESULT;
      S_K_DELTA:   state_next = (current_tempo == '0) ? S_K_FIN : S_K_MUL;
      S_K_MUL:     state_next = S_K_DIV;
      S_K_DIV:     state_next = S_K_WAIT;
      S_K_WAIT:    if (div_done) state_next = S_K_FIN;
      S_K_FIN:     state_next = S_RESULT;
      S_LOAD_DIV:  state_next = S_LOAD_WAIT;
      S_LOAD_WAIT: if (div_done) state_next = S_IDLE;
      S_RESULT:    if (!out_valid || out_item.ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == S_IDLE);
    out_load     = (state == S_RESULT) && (!out_valid || out_item.ready);
    div_start    = 1'b0;
    div_dividend = DIV_W'(prod);
    div_divisor  = DVS_W'(eff_tpq);
    mul_b        = tempo_per_tick;
    unique case (state)
      S_TUS_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(tus_r);
        div_divisor  = US_PER_UNIT;
      end
      S_T2T_DIV:   div_start = 1'b1;
      S_MS_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(acc);
        div_divisor  = UNITS_PER_MS_DIV;
      end
      S_K_DIV: begin
        div_start   = 1'b1;
        div_divisor = current_tempo;
      end
      S_LOAD_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(new_tempo);
      end
      S_T2T_MUL_R: mul_b = TEMPO_W'(tempo_remainder);
      S_K_MUL:     mul_b = TEMPO_W'(eff_tpq);
      default: begin
      end
    endcase
  end

  // Configuration, anchor, tempo and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tpq             <= TPQ_RESET;
      default_tempo   <= DEF_TEMPO_RESET;
      anchor_ticks    <= '0;
      anchor_time     <= '0;
      current_tempo   <= DEF_TEMPO_RESET;
      tempo_per_tick  <= TPT_RESET;
      tempo_remainder <= TREM_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TPQ) tpq <= cfg_data[TPQ_W-1:0];
        else if (cfg_index == REG_DEF_TEMPO) default_tempo <= cfg_data[TEMPO_W-1:0];
      end
      if (state == S_DECODE && op_e == OP_RESTART) begin
        anchor_ticks <= '0;
        anchor_time  <= '0;
      end
      // move the anchor with the old tempo before reloading it
      if (state == S_T2T_FIN && op_e == OP_SET_TEMPO) begin
        anchor_time  <= t2t_val;
        anchor_ticks <= date_r;
      end
      if (state == S_LOAD_WAIT && div_done) begin
        current_tempo   <= new_tempo;
        tempo_per_tick  <= div_quo[TEMPO_W-1:0];
        tempo_remainder <= div_rem[TPQ_W-1:0];
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_item.ready) out_valid <= 1'b0;
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_item.valid) begin
      op_r   <= in_item.op;
      date_r <= in_item.date;
      tus_r  <= in_item.tempo_us;
    end
    unique case (state)
      S_DECODE: begin
        if (op_e == OP_MS2T) date_r <= date_r * UNITS_PER_MS;
        if (op_e == OP_RESTART) new_tempo <= default_tempo;
      end
      S_TUS_WAIT:  if (div_done) new_tempo <= tus_q;
      S_T2T_DELTA: begin
        if (date_r >= anchor_ticks) begin
          delta <= date_r - anchor_ticks;
          neg   <= 1'b0;
        end else begin
          delta <= anchor_ticks - date_r;
          neg   <= 1'b1;
        end
      end
      S_T2T_MUL_Q: prod <= PROD_W'(delta) * PROD_W'(mul_b);
      S_T2T_MUL_R: begin
        acc  <= prod[DATE_W-1:0];
        prod <= PROD_W'(delta) * PROD_W'(mul_b);
      end
      S_T2T_WAIT:  if (div_done) acc <= acc + div_quo[DATE_W-1:0];
      S_T2T_FIN: begin
        result_val <= t2t_val;
        acc        <= t2t_val;
      end
      S_MS_WAIT:   if (div_done) result_val <= div_quo[DATE_W-1:0];
      S_K_DELTA: begin
        acc <= DATE_W'(1);
        if (date_r >= anchor_time) begin
          delta <= date_r - anchor_time;
          neg   <= 1'b0;
        end else begin
          delta <= anchor_time - date_r;
          neg   <= 1'b1;
        end
      end
      S_K_MUL:     prod <= PROD_W'(delta) * PROD_W'(mul_b);
      S_K_WAIT:    if (div_done) acc <= k_sat;
      S_K_FIN:     result_val <= neg ? (anchor_ticks - acc) : (anchor_ticks + acc);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= result_val;
  end

  assign in_item.ready           = in_ready;
  assign out_item.valid          = out_valid;
  assign out_item.converted_date = out_data;

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_item.valid && in_item.ready) |=> (state == S_DECODE))
    else $error("accepted item not decoded");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_TUS_WAIT || state == S_T2T_WAIT || state == S_MS_WAIT ||
                  state == S_K_WAIT || state == S_LOAD_WAIT))
    else $error("divider finished outside a wait state");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_item.valid && !out_item.ready) |=>
      (out_item.valid && $stable(out_item.converted_date)))
    else $error("result item changed while stalled");

endmodule

`default_nettype wire

@@ design/mttc_divider.sv @@
// Shared restoring divider: one quotient bit per cycle over a 48-bit dividend.
// Depends on mttc_pkg for widths.
`default_nettype none

module mttc_divider import mttc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient,
  output logic [DVS_W-1:0]  remainder
);

  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("divider started while busy");
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(running) && !running))
    else $error("divider done without a run");
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
